/* rtl/clq_pkg.sv */
// Shared constants, codes and the command word type of the argument quoter.
package clq_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_BEGIN_WORD = 2'd0;
  localparam logic [1:0] OP_DATA_BYTE  = 2'd1;
  localparam logic [1:0] OP_END_WORD   = 2'd2;
  localparam logic [1:0] OP_END_CMD    = 2'd3;

  // Error codes carried with each output word.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_QUOTE    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Characters.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Longest backslash run that is held.
  localparam int MAX_RUN = 31;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);
  // A doubled run plus one needs one more bit.
  localparam int CNT_W   = RUN_W + 1;

  // Depth of the queue between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  // One command for the back end: an optional leading space, a run of
  // backslashes, then one final byte that closes the item's output.
  typedef struct packed {
    logic             lead_space;
    logic [CNT_W-1:0] run;
    logic [7:0]       final_byte;
    logic [1:0]       final_err;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/command_line_argument_quoter.sv */
// Top level of the command line argument quoter.
//
// The block takes the words of a command as a stream of operations (begin
// word, data byte, end word, end command) and emits the quoted command line
// at most one output word per cycle. Every word is opened with a quote and every
// word after the program name is preceded by a space. Bytes of the program
// name pass unchanged, and a quote there is flagged with error code 1. In
// arguments, backslashes are held as a count of up to 31: before a quote the
// run is doubled plus one, before the end of a word it is doubled, and before
// any other byte it goes out as it is. A backslash past the limit yields one
// word with a zero byte and error code 2 that is not part of the line. End
// command emits a NUL and returns the block to its reset state. The front end
// takes each input word while the queue is not full, classifies it and queues
// a command in a two-entry queue; a backslash inside an argument that stays
// within the limit queues nothing. The back end loads a command from the queue
// and then emits its output words one per cycle while the output does not
// stall; the input stalls only while the queue is full.
// The last flag marks the final output word caused by each input word.
module command_line_argument_quoter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] error_o,
  output logic       last_o
);
  import clq_pkg::*;

  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  fifo_stat_t stat;

  // Front end: handshake on the input side, word and run state.
  clq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .stat_i      (stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // The queue decouples the stall of the two sides.
  clq_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (stat)
  );

  // Back end: expands commands and holds the registered output word.
  clq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/clq_front.sv */
// Front end: accepts input words, tracks word state and builds commands.
module clq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        data_byte_i,
  input  clq_pkg::fifo_stat_t stat_i,
  output logic              push_o,
  output clq_pkg::cmd_t     cmd_o
);
  import clq_pkg::*;

  logic             first_word_next_q, first_word_next_d;
  logic             in_prog_q, in_prog_d;
  logic [RUN_W-1:0] pend_q, pend_d;
  logic             accept;
  logic             has_out;
  cmd_t             cmd;

  assign in_stall_o = stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;

  always_comb begin
    first_word_next_d = first_word_next_q;
    in_prog_d         = in_prog_q;
    pend_d            = pend_q;
    has_out           = 1'b1;
    cmd.lead_space    = 1'b0;
    cmd.run           = '0;
    cmd.final_byte    = CH_QUOTE;
    cmd.final_err     = ERR_NONE;
    case (op_i)
      OP_BEGIN_WORD: begin
        if (first_word_next_q) begin
          first_word_next_d = 1'b0;
          in_prog_d         = 1'b1;
        end else begin
          cmd.lead_space = 1'b1;
          in_prog_d      = 1'b0;
        end
        pend_d = '0;
      end
      OP_DATA_BYTE: begin
        if (in_prog_q) begin
          cmd.final_byte = data_byte_i;
          cmd.final_err  = (data_byte_i == CH_QUOTE) ? ERR_QUOTE : ERR_NONE;
        end else if (data_byte_i == CH_BSLASH) begin
          if (pend_q >= RUN_W'(MAX_RUN)) begin
            cmd.final_byte = CH_NUL;
            cmd.final_err  = ERR_OVERFLOW;
          end else begin
            has_out = 1'b0;
            pend_d  = pend_q + RUN_W'(1);
          end
        end else if (data_byte_i == CH_QUOTE) begin
          cmd.run = {pend_q, 1'b1};
          pend_d  = '0;
        end else begin
          cmd.run        = {1'b0, pend_q};
          cmd.final_byte = data_byte_i;
          pend_d         = '0;
        end
      end
      OP_END_WORD: begin
        if (!in_prog_q) begin
          cmd.run = {pend_q, 1'b0};
        end
        in_prog_d = 1'b0;
        pend_d    = '0;
      end
      default: begin
        cmd.final_byte    = CH_NUL;
        first_word_next_d = 1'b1;
        in_prog_d         = 1'b0;
        pend_d            = '0;
      end
    endcase
  end

  assign push_o = accept && has_out;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_word_next_q <= 1'b1;
      in_prog_q         <= 1'b0;
      pend_q            <= '0;
    end else if (accept) begin
      first_word_next_q <= first_word_next_d;
      in_prog_q         <= in_prog_d;
      pend_q            <= pend_d;
    end
  end

endmodule

/* rtl/clq_fifo.sv */
// Short command queue between the front end and the back end.
module clq_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  clq_pkg::cmd_t       push_cmd_i,
  input  logic                pop_i,
  output clq_pkg::cmd_t       head_o,
  output clq_pkg::fifo_stat_t stat_o
);
  import clq_pkg::*;

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] level_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (level_q == LVL_W'(FIFO_DEPTH));
  assign stat_o.empty = (level_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - LVL_W'(1);
      end
    end
  end

endmodule

/* rtl/clq_back.sv */
// Back end: expands one command into output words, one word per cycle while the output is not stalled.
module clq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clq_pkg::cmd_t       head_i,
  input  clq_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          error_o,
  output logic                last_o
);
  import clq_pkg::*;

  logic             cur_valid_q;
  logic             space_q;
  logic [CNT_W-1:0] run_q;
  logic [7:0]       byte_q;
  logic [1:0]       err_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic [1:0]       out_err_q;
  logic             out_last_q;
  logic             advance;

  assign pop_o   = !cur_valid_q && !stat_i.empty;
  assign advance = cur_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (advance && !space_q && run_q == '0) begin
        cur_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      space_q <= head_i.lead_space;
      run_q   <= head_i.run;
      byte_q  <= head_i.final_byte;
      err_q   <= head_i.final_err;
    end else if (advance) begin
      if (space_q) begin
        space_q <= 1'b0;
      end else if (run_q != '0) begin
        run_q <= run_q - CNT_W'(1);
      end
    end
    if (advance) begin
      if (space_q) begin
        out_byte_q <= CH_SPACE;
        out_err_q  <= ERR_NONE;
        out_last_q <= 1'b0;
      end else if (run_q != '0) begin
        out_byte_q <= CH_BSLASH;
        out_err_q  <= ERR_NONE;
        out_last_q <= 1'b0;
      end else begin
        out_byte_q <= byte_q;
        out_err_q  <= err_q;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign error_o     = out_err_q;
  assign last_o      = out_last_q;

endmodule
